### sv/triple_timer_counter_channel_top_defines.svh
// ----------------------------------------------------------------------------
// triple timer counter channel assertion macros
// shared property forms for the timer channel checks
// ----------------------------------------------------------------------------
`ifndef TRIPLE_TIMER_COUNTER_CHANNEL_TOP_DEFINES_SVH
`define TRIPLE_TIMER_COUNTER_CHANNEL_TOP_DEFINES_SVH

// same-cycle implication
`define TTC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttc check failed");

// next-cycle implication
`define TTC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttc check failed");

`endif

### sv/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// types and constants shared by the timer channel modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttc_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int MATCH_COUNT = 3;
    localparam int PRESC_BITS  = 16;
    localparam int NDIV_BITS   = 4;
    localparam int STAT_BITS   = 6;
    localparam int DATA_BITS   = 32;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [3:0] REG_CLKCTRL  = 4'd0;
    localparam logic [3:0] REG_CNTCTRL  = 4'd1;
    localparam logic [3:0] REG_COUNT    = 4'd2;
    localparam logic [3:0] REG_INTERVAL = 4'd3;
    localparam logic [3:0] REG_MATCH0   = 4'd4;
    localparam logic [3:0] REG_STATUS   = 4'd7;
    localparam logic [3:0] REG_ENABLE   = 4'd8;

    localparam int ST_INTV   = 0;
    localparam int ST_MATCH0 = 1;
    localparam int ST_OVR    = 4;

    localparam int CC_RESET_BIT = 4;
    localparam int CC_WEN_BIT   = 5;
    localparam int CC_WPOL_BIT  = 6;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [3:0]           reg_index;
        logic [DATA_BITS-1:0] write_data;
    } ttc_cmd_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 irq;
        logic                 wave_out;
    } ttc_rsp_t;

endpackage

### sv/ttc_core.sv
// ----------------------------------------------------------------------------
// ttc_core
// timer channel state: prescaler, counter, match, status and register file
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttc_core
    import ttc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  ttc_cmd_t cmd,
    output ttc_rsp_t rsp
);

    typedef struct packed {
        logic [NDIV_BITS-1:0] n;
        logic                 en;
    } ttc_clk_cfg_t;

    typedef struct packed {
        logic wpol;
        logic wen;
        logic match_en;
        logic down;
        logic intv;
        logic stop;
    } ttc_cnt_ctrl_t;

    ttc_clk_cfg_t          clk_cfg_reg, clk_cfg_next;
    ttc_cnt_ctrl_t         cnt_ctrl_reg, cnt_ctrl_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PRESC_BITS-1:0] presc_reg, presc_next;
    logic [COUNT_BITS-1:0] interval_reg, interval_next;
    logic [COUNT_BITS-1:0] match_reg [MATCH_COUNT];
    logic [COUNT_BITS-1:0] match_next [MATCH_COUNT];
    logic [STAT_BITS-1:0]  status_reg, status_next;
    logic [STAT_BITS-1:0]  enable_reg, enable_next;
    logic                  wave_reg, wave_next;

    logic [COUNT_BITS-1:0] adv_count;
    logic [STAT_BITS-1:0]  adv_set;
    logic                  adv_wave;
    logic                  adv_wrapped;
    logic                  do_adv;
    logic [PRESC_BITS:0]   presc_inc;
    logic [PRESC_BITS:0]   presc_limit;
    logic [DATA_BITS-1:0]  rd;

    // one counter step
    always_comb
    begin
        adv_wrapped = 1'b0;
        adv_set     = '0;
        adv_count   = count_reg;
        if (cnt_ctrl_reg.intv)
        begin
            if (cnt_ctrl_reg.down)
            begin
                if (count_reg == '0)
                begin
                    adv_count   = interval_reg;
                    adv_wrapped = 1'b1;
                end
                else
                begin
                    adv_count = count_reg - COUNT_BITS'(1);
                end
            end
            else
            begin
                if (count_reg >= interval_reg)
                begin
                    adv_count   = '0;
                    adv_wrapped = 1'b1;
                end
                else
                begin
                    adv_count = count_reg + COUNT_BITS'(1);
                end
            end
            adv_set[ST_INTV] = adv_wrapped;
        end
        else
        begin
            if (cnt_ctrl_reg.down)
            begin
                adv_wrapped = (count_reg == '0);
                adv_count   = count_reg - COUNT_BITS'(1);
            end
            else
            begin
                adv_wrapped = (count_reg == '1);
                adv_count   = count_reg + COUNT_BITS'(1);
            end
            adv_set[ST_OVR] = adv_wrapped;
        end
        adv_wave = adv_wrapped ? 1'b0 : wave_reg;
        if (cnt_ctrl_reg.match_en)
        begin
            for (int i = 0; i < MATCH_COUNT; i++)
            begin
                if (match_reg[i] == adv_count)
                begin
                    adv_set[ST_MATCH0 + i] = 1'b1;
                    if (i == 0)
                    begin
                        adv_wave = 1'b1;
                    end
                end
            end
        end
    end

    assign presc_inc   = {1'b0, presc_reg} + (PRESC_BITS + 1)'(1);
    assign presc_limit = (PRESC_BITS + 1)'(1) << ({1'b0, clk_cfg_reg.n} + 5'd1);

    always_comb
    begin
        clk_cfg_next  = clk_cfg_reg;
        cnt_ctrl_next = cnt_ctrl_reg;
        count_next    = count_reg;
        presc_next    = presc_reg;
        interval_next = interval_reg;
        match_next    = match_reg;
        status_next   = status_reg;
        enable_next   = enable_reg;
        wave_next     = wave_reg;
        do_adv        = 1'b0;
        rd            = '0;

        case (cmd.opcode)
            OP_TICK:
            begin
                if (!cnt_ctrl_reg.stop)
                begin
                    if (clk_cfg_reg.en)
                    begin
                        if (presc_inc >= presc_limit)
                        begin
                            presc_next = '0;
                            do_adv     = 1'b1;
                        end
                        else
                        begin
                            presc_next = presc_inc[PRESC_BITS-1:0];
                        end
                    end
                    else
                    begin
                        presc_next = '0;
                        do_adv     = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                unique case (cmd.reg_index)
                    REG_CLKCTRL:  rd = DATA_BITS'(clk_cfg_reg);
                    REG_CNTCTRL:  rd = DATA_BITS'({cnt_ctrl_reg.wpol, cnt_ctrl_reg.wen, 1'b0,
                                                   cnt_ctrl_reg.match_en, cnt_ctrl_reg.down,
                                                   cnt_ctrl_reg.intv, cnt_ctrl_reg.stop});
                    REG_COUNT:    rd = DATA_BITS'(count_reg);
                    REG_INTERVAL: rd = DATA_BITS'(interval_reg);
                    REG_STATUS:
                    begin
                        rd          = DATA_BITS'(status_reg);
                        status_next = '0;
                    end
                    REG_ENABLE:   rd = DATA_BITS'(enable_reg);
                    default:      rd = '0;
                endcase
                for (int i = 0; i < MATCH_COUNT; i++)
                begin
                    if (cmd.reg_index == REG_MATCH0 + 4'(i))
                    begin
                        rd = DATA_BITS'(match_reg[i]);
                    end
                end
            end
            OP_WRITE:
            begin
                unique case (cmd.reg_index)
                    REG_CLKCTRL:  clk_cfg_next = cmd.write_data[NDIV_BITS:0];
                    REG_CNTCTRL:
                    begin
                        cnt_ctrl_next = {cmd.write_data[CC_WPOL_BIT], cmd.write_data[CC_WEN_BIT],
                                         cmd.write_data[3:0]};
                        if (cmd.write_data[CC_RESET_BIT])
                        begin
                            count_next = '0;
                            presc_next = '0;
                            wave_next  = 1'b0;
                        end
                    end
                    REG_INTERVAL: interval_next = cmd.write_data[COUNT_BITS-1:0];
                    REG_ENABLE:   enable_next   = cmd.write_data[STAT_BITS-1:0];
                    default:      ;
                endcase
                for (int i = 0; i < MATCH_COUNT; i++)
                begin
                    if (cmd.reg_index == REG_MATCH0 + 4'(i))
                    begin
                        match_next[i] = cmd.write_data[COUNT_BITS-1:0];
                    end
                end
            end
            default: ;
        endcase

        if (do_adv)
        begin
            count_next  = adv_count;
            status_next = status_reg | adv_set;
            wave_next   = adv_wave;
        end

        rsp.read_data = rd;
        rsp.irq       = |(status_next & enable_next);
        rsp.wave_out  = cnt_ctrl_next.wen ? 1'b0 : (wave_next ^ cnt_ctrl_next.wpol);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_cfg_reg  <= '0;
            cnt_ctrl_reg <= '{stop: 1'b1, default: 1'b0};
            count_reg    <= '0;
            presc_reg    <= '0;
            interval_reg <= '0;
            for (int i = 0; i < MATCH_COUNT; i++)
            begin
                match_reg[i] <= '0;
            end
            status_reg   <= '0;
            enable_reg   <= '0;
            wave_reg     <= 1'b0;
        end
        else if (fire)
        begin
            clk_cfg_reg  <= clk_cfg_next;
            cnt_ctrl_reg <= cnt_ctrl_next;
            count_reg    <= count_next;
            presc_reg    <= presc_next;
            interval_reg <= interval_next;
            match_reg    <= match_next;
            status_reg   <= status_next;
            enable_reg   <= enable_next;
            wave_reg     <= wave_next;
        end
    end

endmodule

### sv/triple_timer_counter_channel_top.sv
// ----------------------------------------------------------------------------
// triple_timer_counter_channel_top
// an item passes the input item register, then the result register
// throughput: one item per cycle unless a held response stalls the input
// reset: async active low, counter stopped, timer state and valid flags zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triple_timer_counter_channel_top_defines.svh"

module triple_timer_counter_channel_top
    import ttc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  ttc_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ttc_rsp_t rsp
);

    logic     s1_valid_reg;
    ttc_cmd_t s1_cmd_reg;
    logic     out_valid_reg;
    ttc_rsp_t out_rsp_reg;
    logic     s1_adv;
    ttc_rsp_t core_rsp;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign cmd_ready = !s1_valid_reg || s1_adv;

    ttc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_adv),
        .cmd   (s1_cmd_reg),
        .rsp   (core_rsp)
    );

    // input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_cmd_reg <= cmd;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

    `TTC_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg)
    `TTC_ASSERT_NOW(a_stall_means_full, !cmd_ready, s1_valid_reg && out_valid_reg && !rsp_ready)
    `TTC_ASSERT_NEXT(a_held_item_kept, s1_valid_reg && !s1_adv, s1_valid_reg)

endmodule

### verif/triple_timer_counter_channel_top_test.sv
// ----------------------------------------------------------------------------
// triple_timer_counter_channel_top_test
// Tests the timer channel through its command and response handshakes. Each
// accepted item (tick, idle, register read or write) runs through a predictor of the
// counter, prescaler, status and waveform state. Every response is checked
// field by field against the oldest prediction. Directed cases come first:
// wrap and match in one step, ignored accesses, a prescale change while
// counting, and the self-clearing reset. Random counter programs with bursty
// items and response stalls follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triple_timer_counter_channel_top_test;
    import ttc_pkg::*;

    localparam logic [1:0] OP_IDLE     = 2'd3;
    localparam logic [3:0] REG_MATCH1  = REG_MATCH0 + 4'd1;
    localparam logic [3:0] REG_MATCH2  = REG_MATCH0 + 4'd2;
    localparam logic [3:0] REG_UNUSED  = 4'd15;
    localparam int CC_STOP_BIT         = 0;
    localparam int CC_INTV_BIT         = 1;
    localparam int CC_DOWN_BIT         = 2;
    localparam int CC_MATCH_BIT        = 3;
    localparam int CK_PRESC_EN_BIT     = 0;
    localparam int RANDOM_ITEMS        = 1350;
    localparam int IDLE_LIMIT          = 2000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    ttc_cmd_t cmd = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    ttc_rsp_t rsp;

    // predicted timer state
    logic [4:0]             clk_cfg;
    bit                     stopped, intv_mode, count_down, match_en, wave_dis, wave_pol;
    logic [COUNT_BITS-1:0]  count_q;
    logic [PRESC_BITS-1:0]  presc_q;
    logic [COUNT_BITS-1:0]  interval_q;
    logic [COUNT_BITS-1:0]  match_q [MATCH_COUNT];
    logic [STAT_BITS-1:0]   status_q;
    logic [STAT_BITS-1:0]   irq_en_q;
    logic                   wave_q;

    ttc_rsp_t pending_rsp [$];
    int       mismatch_count = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    int       idle_cycles = 0;
    int       stall_mode = 0;
    int       stall_left = 0;
    int       stall_phase = 0;

    triple_timer_counter_channel_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_timer_state();
        clk_cfg    = '0;
        stopped    = 1'b1;
        intv_mode  = 1'b0;
        count_down = 1'b0;
        match_en   = 1'b0;
        wave_dis   = 1'b0;
        wave_pol   = 1'b0;
        count_q    = '0;
        presc_q    = '0;
        interval_q = '0;
        for (int i = 0; i < MATCH_COUNT; i++)
            match_q[i] = '0;
        status_q   = '0;
        irq_en_q   = '0;
        wave_q     = 1'b0;
    endfunction

    function automatic void advance_count();
        logic [COUNT_BITS-1:0] c;
        bit                    wrapped;
        c = count_q;
        wrapped = 1'b0;
        if (intv_mode)
        begin
            if (count_down)
            begin
                if (c == '0)
                begin
                    c = interval_q;
                    wrapped = 1'b1;
                end
                else
                    c = c - COUNT_BITS'(1);
            end
            else if (c >= interval_q)
            begin
                c = '0;
                wrapped = 1'b1;
            end
            else
                c = c + COUNT_BITS'(1);
            if (wrapped)
                status_q[ST_INTV] = 1'b1;
        end
        else
        begin
            if (count_down)
            begin
                wrapped = (c == '0);
                c = c - COUNT_BITS'(1);
            end
            else
            begin
                wrapped = (c == '1);
                c = c + COUNT_BITS'(1);
            end
            if (wrapped)
                status_q[ST_OVR] = 1'b1;
        end
        count_q = c;
        if (wrapped)
            wave_q = 1'b0;
        // match0 sets the wave after a wrap has cleared it
        if (match_en)
            for (int i = 0; i < MATCH_COUNT; i++)
                if (match_q[i] == c)
                begin
                    status_q[ST_MATCH0 + i] = 1'b1;
                    if (i == 0)
                        wave_q = 1'b1;
                end
    endfunction

    function automatic void timer_tick();
        logic [31:0] presc_next;
        logic [31:0] presc_limit;
        if (stopped)
            return;
        if (clk_cfg[CK_PRESC_EN_BIT])
        begin
            presc_limit = 32'd1 << (32'(clk_cfg[4:1]) + 32'd1);
            presc_next = 32'(presc_q) + 32'd1;
            if (presc_next >= presc_limit)
            begin
                presc_q = '0;
                advance_count();
            end
            else
                presc_q = presc_next[PRESC_BITS-1:0];
        end
        else
        begin
            presc_q = '0;
            advance_count();
        end
    endfunction

    function automatic logic [DATA_BITS-1:0] read_register(logic [3:0] idx);
        logic [DATA_BITS-1:0] v;
        v = '0;
        case (idx)
            REG_CLKCTRL:  v = DATA_BITS'(clk_cfg);
            REG_CNTCTRL:
            begin
                v[CC_STOP_BIT]  = stopped;
                v[CC_INTV_BIT]  = intv_mode;
                v[CC_DOWN_BIT]  = count_down;
                v[CC_MATCH_BIT] = match_en;
                v[CC_WEN_BIT]   = wave_dis;
                v[CC_WPOL_BIT]  = wave_pol;
            end
            REG_COUNT:    v = DATA_BITS'(count_q);
            REG_INTERVAL: v = DATA_BITS'(interval_q);
            REG_MATCH0, REG_MATCH1, REG_MATCH2:
                if (int'(idx - REG_MATCH0) < MATCH_COUNT)
                    v = DATA_BITS'(match_q[int'(idx - REG_MATCH0)]);
            REG_STATUS:
            begin
                v = DATA_BITS'(status_q);
                status_q = '0;
            end
            REG_ENABLE:   v = DATA_BITS'(irq_en_q);
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic void write_register(logic [3:0] idx, logic [DATA_BITS-1:0] d);
        case (idx)
            REG_CLKCTRL:  clk_cfg = d[4:0];
            REG_CNTCTRL:
            begin
                stopped    = d[CC_STOP_BIT];
                intv_mode  = d[CC_INTV_BIT];
                count_down = d[CC_DOWN_BIT];
                match_en   = d[CC_MATCH_BIT];
                wave_dis   = d[CC_WEN_BIT];
                wave_pol   = d[CC_WPOL_BIT];
                if (d[CC_RESET_BIT])
                begin
                    count_q = '0;
                    presc_q = '0;
                    wave_q  = 1'b0;
                end
            end
            REG_INTERVAL: interval_q = d[COUNT_BITS-1:0];
            REG_MATCH0, REG_MATCH1, REG_MATCH2:
                if (int'(idx - REG_MATCH0) < MATCH_COUNT)
                    match_q[int'(idx - REG_MATCH0)] = d[COUNT_BITS-1:0];
            REG_ENABLE:   irq_en_q = d[STAT_BITS-1:0];
            default:      ;
        endcase
    endfunction

    function automatic ttc_rsp_t predict_timer_response(ttc_cmd_t c);
        ttc_rsp_t r;
        r = '0;
        case (c.opcode)
            OP_TICK:  timer_tick();
            OP_READ:  r.read_data = read_register(c.reg_index);
            OP_WRITE: write_register(c.reg_index, c.write_data);
            default:  ;
        endcase
        r.irq = |(status_q & irq_en_q);
        r.wave_out = wave_dis ? 1'b0 : (wave_q ^ wave_pol);
        return r;
    endfunction

    function automatic logic [31:0] cntctrl_word(bit stop, bit intv, bit down, bit match,
                                                 bit clr, bit wdis, bit pol);
        logic [31:0] w;
        w = '0;
        w[CC_STOP_BIT]  = stop;
        w[CC_INTV_BIT]  = intv;
        w[CC_DOWN_BIT]  = down;
        w[CC_MATCH_BIT] = match;
        w[CC_RESET_BIT] = clr;
        w[CC_WEN_BIT]   = wdis;
        w[CC_WPOL_BIT]  = pol;
        return w;
    endfunction

    // mostly small so that intervals and matches come around often
    function automatic logic [31:0] small_or_wide(int top);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, top);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(logic [1:0] op, logic [3:0] idx, logic [31:0] data);
        ttc_cmd_t c;
        c.opcode = op;
        c.reg_index = idx;
        c.write_data = data;
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        cmd <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        pending_rsp.push_back(predict_timer_response(c));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic do_ticks(int n);
        repeat (n) send_item(OP_TICK, REG_CLKCTRL, $urandom);
    endtask

    task automatic do_read(logic [3:0] idx);
        send_item(OP_READ, idx, $urandom);
    endtask

    task automatic do_write(logic [3:0] idx, logic [31:0] data);
        send_item(OP_WRITE, idx, data);
    endtask

    task automatic test_wrap_and_match();
        do_write(REG_ENABLE, 32'hFFFF_FFFF);
        do_write(REG_INTERVAL, 32'hFFFF_FFFF);
        do_write(REG_CNTCTRL, cntctrl_word(0, 1, 1, 1, 0, 0, 1));
        do_read(REG_CNTCTRL);
        do_ticks(1);
        do_write(REG_CNTCTRL, cntctrl_word(0, 0, 0, 1, 0, 0, 0));
        do_ticks(1);
        do_read(REG_STATUS);
        do_read(REG_STATUS);
    endtask

    task automatic test_ignored_accesses();
        do_write(REG_COUNT, 32'h1234_5678);
        do_write(REG_STATUS, 32'hFFFF_FFFF);
        do_write(REG_UNUSED, 32'hFFFF_FFFF);
        do_read(REG_UNUSED);
        send_item(OP_IDLE, REG_UNUSED, 32'hFFFF_FFFF);
    endtask

    task automatic test_prescale_change();
        do_write(REG_CLKCTRL, 32'hFFFF_FFFF);
        do_ticks(3);
        do_write(REG_CLKCTRL, 32'h0000_0001);
        do_ticks(1);
    endtask

    task automatic test_counter_reset();
        do_write(REG_CNTCTRL, cntctrl_word(1, 0, 0, 0, 1, 0, 0));
        do_ticks(1);
        do_read(REG_COUNT);
        do_write(REG_CNTCTRL, cntctrl_word(0, 0, 1, 0, 0, 1, 0));
        do_ticks(1);
    endtask

    task automatic test_random_traffic(int item_total);
        int          first;
        int          pick;
        logic [31:0] data;
        first = items_sent;
        while (items_sent - first < item_total)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                data = $urandom;
                if ($urandom_range(0, 7) != 0)
                    data[4:1] = 4'($urandom_range(0, 2));
                do_write(REG_CLKCTRL, data);
            end
            if ($urandom_range(0, 1) == 0)
                do_write(REG_INTERVAL, small_or_wide(24));
            for (int i = 0; i < MATCH_COUNT; i++)
                if ($urandom_range(0, 2) == 0)
                    do_write(REG_MATCH0 + 4'(i), small_or_wide(24));
            if ($urandom_range(0, 3) == 0)
                do_write(REG_ENABLE, $urandom);
            do_write(REG_CNTCTRL,
                     cntctrl_word($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0,
                                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                                  1'($urandom_range(0, 1))) | ($urandom & 32'hFFFF_FF80));
            repeat ($urandom_range(8, 40))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    do_ticks(1);
                else if (pick < 82)
                    do_read(REG_STATUS);
                else if (pick < 90)
                    do_read(4'($urandom_range(0, 8)));
                else
                    send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
            end
        end
    endtask

    // receiver stalls in phases: always ready, mostly ready, mostly stalled, periodic
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 2) == 0);
            default: rsp_ready <= (stall_phase % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin : check_rsp
        ttc_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %h", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h, actual %h",
                             $time, want.read_data, rsp.read_data);
                    mismatch_count++;
                end
                if (rsp.irq !== want.irq)
                begin
                    $display("%0t: irq expected %b, actual %b", $time, want.irq, rsp.irq);
                    mismatch_count++;
                end
                if (rsp.wave_out !== want.wave_out)
                begin
                    $display("%0t: wave_out expected %b, actual %b",
                             $time, want.wave_out, rsp.wave_out);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        clear_timer_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_wrap_and_match();
        test_ignored_accesses();
        test_prescale_change();
        test_counter_reset();
        test_random_traffic(RANDOM_ITEMS);

        cmd_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/ttc_pkg.sv
sv/ttc_core.sv
sv/triple_timer_counter_channel_top.sv
verif/triple_timer_counter_channel_top_test.sv
